@@ design/tpp_pkg.sv @@
// Shared types, status codes and saturation helpers for the trapezoid profile planner.
// Used by the front end and the top of the planner; depends on nothing.
`timescale 1ns / 1ps

package tpp_pkg;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_AXIS   = 2'd1,
        ST_BAD_PARAM = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] dist_x;
        logic signed [31:0] dist_y;
        logic signed [31:0] dist_z;
        logic signed [31:0] start_speed_x;
        logic signed [31:0] start_speed_y;
        logic signed [31:0] start_speed_z;
        logic signed [31:0] cruise_speed_x;
        logic signed [31:0] cruise_speed_y;
        logic signed [31:0] cruise_speed_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
    } seg_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] time_total;
        logic signed [31:0] time_accel;
        logic signed [31:0] time_cruise;
        logic signed [31:0] time_decel;
        logic signed [31:0] dist_accel;
        logic signed [31:0] dist_cruise;
        logic signed [31:0] dist_decel;
    } plan_t;

    // Front end result: selected axis plus the operands of the first division and the root.
    typedef struct packed {
        status_t            status;
        logic signed [31:0] s;
        logic signed [31:0] v0;
        logic signed [31:0] vt;
        logic signed [31:0] a;
        logic               num_neg;
        logic [61:0]        num_mag;
        logic [32:0]        den;
        logic [63:0]        rad;
    } front_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] s;
        logic signed [31:0] v0;
        logic signed [31:0] vt;
        logic signed [31:0] a;
        logic               num_neg;
        logic [63:0]        rad;
    } d1_side_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] s;
        logic signed [31:0] v0;
        logic signed [31:0] vt;
        logic signed [31:0] a;
        logic signed [31:0] s_acc;
        logic signed [33:0] s_uni;
        logic               trap;
    } sq_side_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] s_acc;
        logic signed [31:0] s_uni;
        logic               dneg;
    } d2_side_t;

    // Signed, saturated result of a sign-magnitude quotient.
    function automatic logic signed [31:0] sat_quot(input logic neg, input logic [31:0] q,
                                                    input logic ovf);
        logic signed [31:0] res;
        if (!neg)
            res = (ovf || q[31]) ? SAT_MAX : $signed(q);
        else
            res = (ovf || (q > 32'h8000_0000)) ? SAT_MIN : $signed(-q);
        return res;
    endfunction

    function automatic logic signed [31:0] sat_wide(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            res = v[31:0];
        else if (v[33])
            res = SAT_MIN;
        else
            res = SAT_MAX;
        return res;
    endfunction

endpackage

@@ design/tpp_front.sv @@
// Front end of the planner: axis selection, parameter check, squares and products.
// Four register stages; depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             seg_valid,
    input  tpp_pkg::seg_t    seg,
    output logic             front_valid,
    output tpp_pkg::front_t  front
);

    tpp_pkg::status_t   sel_status;
    logic signed [31:0] sel_s;
    logic signed [31:0] sel_v0;
    logic signed [31:0] sel_vt;
    logic signed [31:0] sel_a;

    logic               s1_vld_reg;
    tpp_pkg::status_t   s1_status_reg;
    logic signed [31:0] s1_s_reg;
    logic signed [31:0] s1_v0_reg;
    logic signed [31:0] s1_vt_reg;
    logic signed [31:0] s1_a_reg;

    logic               s2_vld_reg;
    tpp_pkg::status_t   s2_status_reg;
    logic signed [31:0] s2_s_reg;
    logic signed [31:0] s2_v0_reg;
    logic signed [31:0] s2_vt_reg;
    logic signed [31:0] s2_a_reg;
    logic signed [63:0] s2_vt2_reg;
    logic signed [63:0] s2_v02_reg;
    logic [61:0]        s2_ash_reg;

    logic               s3_vld_reg;
    tpp_pkg::status_t   s3_status_reg;
    logic signed [31:0] s3_s_reg;
    logic signed [31:0] s3_v0_reg;
    logic signed [31:0] s3_vt_reg;
    logic signed [31:0] s3_a_reg;
    logic signed [63:0] s3_n_reg;
    logic [63:0]        s3_rad_reg;

    logic               s4_vld_reg;
    tpp_pkg::front_t    s4_reg;
    tpp_pkg::front_t    s4_next;

    // The first axis with a non-negative distance wins.
    always_comb
    begin
        sel_status = tpp_pkg::ST_OK;
        sel_s      = seg.dist_z;
        sel_v0     = seg.start_speed_z;
        sel_vt     = seg.cruise_speed_z;
        sel_a      = seg.accel_z;
        if (!seg.dist_x[31])
        begin
            sel_s  = seg.dist_x;
            sel_v0 = seg.start_speed_x;
            sel_vt = seg.cruise_speed_x;
            sel_a  = seg.accel_x;
        end
        else if (!seg.dist_y[31])
        begin
            sel_s  = seg.dist_y;
            sel_v0 = seg.start_speed_y;
            sel_vt = seg.cruise_speed_y;
            sel_a  = seg.accel_y;
        end
        else if (seg.dist_z[31])
        begin
            sel_status = tpp_pkg::ST_NO_AXIS;
        end
        if (sel_status == tpp_pkg::ST_OK &&
            (sel_a[31] || sel_a == '0 || sel_vt[31] || sel_vt == '0))
        begin
            sel_status = tpp_pkg::ST_BAD_PARAM;
        end
    end

    always_comb
    begin
        s4_next         = s4_reg;
        s4_next.status  = s3_status_reg;
        s4_next.s       = s3_s_reg;
        s4_next.v0      = s3_v0_reg;
        s4_next.vt      = s3_vt_reg;
        s4_next.a       = s3_a_reg;
        s4_next.num_neg = s3_n_reg[63];
        s4_next.num_mag = s3_n_reg[63] ? 62'(-s3_n_reg) : s3_n_reg[61:0];
        s4_next.den     = {s3_a_reg, 1'b0};
        s4_next.rad     = s3_rad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= seg_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_status_reg <= sel_status;
            s1_s_reg      <= sel_s;
            s1_v0_reg     <= sel_v0;
            s1_vt_reg     <= sel_vt;
            s1_a_reg      <= sel_a;

            s2_status_reg <= s1_status_reg;
            s2_s_reg      <= s1_s_reg;
            s2_v0_reg     <= s1_v0_reg;
            s2_vt_reg     <= s1_vt_reg;
            s2_a_reg      <= s1_a_reg;
            s2_vt2_reg    <= s1_vt_reg * s1_vt_reg;
            s2_v02_reg    <= s1_v0_reg * s1_v0_reg;
            s2_ash_reg    <= s1_a_reg[30:0] * s1_s_reg[31:1];

            s3_status_reg <= s2_status_reg;
            s3_s_reg      <= s2_s_reg;
            s3_v0_reg     <= s2_v0_reg;
            s3_vt_reg     <= s2_vt_reg;
            s3_a_reg      <= s2_a_reg;
            s3_n_reg      <= s2_vt2_reg - s2_v02_reg;
            s3_rad_reg    <= {1'b0, s2_ash_reg, 1'b0} + $unsigned(s2_v02_reg);

            s4_reg        <= s4_next;
        end
    end

    assign front_valid = s4_vld_reg;
    assign front       = s4_reg;

endmodule

@@ design/tpp_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, 32-bit quotient plus overflow flag.
// A tag travels with each operand pair; depends on nothing.
`timescale 1ns / 1ps

module tpp_div_pipe #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 33,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             req_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             res_valid,
    output logic [31:0]      quot,
    output logic             quot_ovf,
    output logic [TAG_W-1:0] res_tag
);

    localparam int QW    = 32;
    localparam int HI_W  = NUM_W - QW;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [HI_W-1:0]  hi;
    logic             ovf_next;
    logic [DEN_W-1:0] rem0_next;

    logic [QW:0]      vld_reg;
    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    lo_reg  [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             ovf_reg [QW+1];
    logic [TAG_W-1:0] tag_reg [QW+1];

    logic [DEN_W:0]   trial_w  [QW];
    logic             ge_w     [QW];
    logic [DEN_W-1:0] rem_next [QW];
    logic [QW-1:0]    lo_next  [QW];

    // A quotient of 2^32 or more shows up as a high part not below the divisor.
    always_comb
    begin
        hi        = num[NUM_W-1:QW];
        ovf_next  = CMP_W'(hi) >= CMP_W'(den);
        rem0_next = ovf_next ? '0 : DEN_W'(hi);
    end

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial_w[k]  = {rem_reg[k], lo_reg[k][QW-1]};
            ge_w[k]     = trial_w[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge_w[k] ? DEN_W'(trial_w[k] - {1'b0, den_reg[k]})
                                  : trial_w[k][DEN_W-1:0];
            lo_next[k]  = {lo_reg[k][QW-2:0], ge_w[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[QW-1:0], req_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem0_next;
            lo_reg[0]  <= num[QW-1:0];
            den_reg[0] <= den;
            ovf_reg[0] <= ovf_next;
            tag_reg[0] <= tag;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                lo_reg[k+1]  <= lo_next[k];
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign res_valid = vld_reg[QW];
    assign quot      = lo_reg[QW];
    assign quot_ovf  = ovf_reg[QW];
    assign res_tag   = tag_reg[QW];

endmodule

@@ design/tpp_sqrt_pipe.sv @@
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// A tag travels with each operand; depends on nothing.
`timescale 1ns / 1ps

module tpp_sqrt_pipe #(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             req_valid,
    input  logic [63:0]      rad,
    input  logic [TAG_W-1:0] tag,
    output logic             res_valid,
    output logic [31:0]      root,
    output logic [TAG_W-1:0] res_tag
);

    localparam int STEPS = 32;

    logic [STEPS:0]   vld_reg;
    logic [33:0]      rem_reg  [STEPS+1];
    logic [31:0]      root_reg [STEPS+1];
    logic [63:0]      x_reg    [STEPS+1];
    logic [TAG_W-1:0] tag_reg  [STEPS+1];

    logic [35:0]      part_w    [STEPS];
    logic [35:0]      trial_w   [STEPS];
    logic             ge_w      [STEPS];
    logic [33:0]      rem_next  [STEPS];
    logic [31:0]      root_next [STEPS];

    // Each step brings down two radicand bits and tries the next root bit.
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            part_w[k]    = {rem_reg[k], x_reg[k][63:62]};
            trial_w[k]   = {2'b00, root_reg[k], 2'b01};
            ge_w[k]      = part_w[k] >= trial_w[k];
            rem_next[k]  = ge_w[k] ? 34'(part_w[k] - trial_w[k]) : part_w[k][33:0];
            root_next[k] = {root_reg[k][30:0], ge_w[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STEPS-1:0], req_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            x_reg[0]    <= rad;
            tag_reg[0]  <= tag;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                x_reg[k+1]    <= {x_reg[k][61:0], 2'b00};
                tag_reg[k+1]  <= tag_reg[k];
            end
        end
    end

    assign res_valid = vld_reg[STEPS];
    assign root      = root_reg[STEPS];
    assign res_tag   = tag_reg[STEPS];

endmodule

@@ design/trapezoid_profile_planner_top.sv @@
// Trapezoid profile planner: one request per clock cycle, sustained, when results are taken.
// The latency from request to result is dominated by the chain of the divider for the
// acceleration distance, the square root and the divider for the phase times, 33 stages each.
// A two-entry output queue lets requests flow while one result waits; a full queue freezes all.
// Reset (rst_n, asynchronous, active low) clears all valid bits and empties the output queue.
`timescale 1ns / 1ps

module trapezoid_profile_planner_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seg_valid,
    output logic            seg_ready,
    input  tpp_pkg::seg_t   seg,
    output logic            plan_valid,
    input  logic            plan_ready,
    output tpp_pkg::plan_t  plan
);

    localparam int NUM2_W = 33 + FRAC_BITS;

    // The whole pipeline moves together; it only stops when the output queue is full.
    logic adv;

    logic              front_valid;
    tpp_pkg::front_t   front;

    tpp_pkg::d1_side_t d1_tag;
    tpp_pkg::d1_side_t d1_res;
    logic              d1_valid;
    logic [31:0]       d1_quot;
    logic              d1_ovf;

    tpp_pkg::sq_side_t sq_tag;
    tpp_pkg::sq_side_t sq_res;
    logic              sq_valid;
    logic [31:0]       sq_root;
    logic signed [31:0] mid_s_acc;
    logic signed [33:0] mid_s_uni;

    logic               p1_vld_reg;
    tpp_pkg::status_t   p1_status_reg;
    logic signed [33:0] p1_diff_reg;
    logic signed [31:0] p1_s_acc_reg;
    logic signed [31:0] p1_s_uni_reg;
    logic               p1_trap_reg;
    logic signed [31:0] p1_a_reg;
    logic signed [31:0] p1_vt_reg;
    logic signed [33:0] p1_diff_next;
    logic signed [31:0] p1_s_acc_next;
    logic signed [31:0] p1_s_uni_next;

    logic               p2_vld_reg;
    logic [NUM2_W-1:0]  p2_num2_reg;
    logic [NUM2_W-1:0]  p2_num3_reg;
    logic signed [31:0] p2_a_reg;
    logic signed [31:0] p2_vt_reg;
    tpp_pkg::d2_side_t  p2_side_reg;
    logic               p2_trap_reg;
    logic [32:0]        p2_dmag_next;
    tpp_pkg::d2_side_t  p2_side_next;

    tpp_pkg::d2_side_t  d2_res;
    logic               d2_valid;
    logic [31:0]        d2_quot;
    logic               d2_ovf;
    logic               d3_valid;
    logic [31:0]        d3_quot;
    logic               d3_ovf;
    logic               d3_trap;

    logic               q1_vld_reg;
    tpp_pkg::status_t   q1_status_reg;
    logic signed [31:0] q1_t_acc_reg;
    logic signed [31:0] q1_t_uni_reg;
    logic signed [31:0] q1_s_acc_reg;
    logic signed [31:0] q1_s_uni_reg;

    logic               q2_vld_reg;
    tpp_pkg::plan_t     q2_item_reg;
    tpp_pkg::plan_t     q2_item_next;

    tpp_pkg::plan_t     ent_reg [2];
    tpp_pkg::plan_t     ent0_next;
    tpp_pkg::plan_t     ent1_next;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               push;
    logic               pop;

    assign adv       = (cnt_reg != 2'd2);
    assign seg_ready = adv;

    // Axis selection, squares and the operands of the first division.
    tpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .seg_valid   (seg_valid),
        .seg         (seg),
        .front_valid (front_valid),
        .front       (front)
    );

    always_comb
    begin
        d1_tag.status  = front.status;
        d1_tag.s       = front.s;
        d1_tag.v0      = front.v0;
        d1_tag.vt      = front.vt;
        d1_tag.a       = front.a;
        d1_tag.num_neg = front.num_neg;
        d1_tag.rad     = front.rad;
    end

    // Acceleration distance: (vt^2 - v0^2) / (2a), truncated toward zero.
    tpp_div_pipe #(
        .NUM_W (62),
        .DEN_W (33),
        .TAG_W ($bits(tpp_pkg::d1_side_t))
    ) u_div_sacc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (front_valid),
        .num       (front.num_mag),
        .den       (front.den),
        .tag       (d1_tag),
        .res_valid (d1_valid),
        .quot      (d1_quot),
        .quot_ovf  (d1_ovf),
        .res_tag   (d1_res)
    );

    // Saturate the acceleration distance and decide between trapezoid and triangle. The
    // triangle peak speed root is computed for every request and simply ignored for a
    // trapezoid.
    always_comb
    begin
        mid_s_acc = tpp_pkg::sat_quot(d1_res.num_neg, d1_quot, d1_ovf);
        mid_s_uni = {{2{d1_res.s[31]}}, d1_res.s} - {mid_s_acc[31], mid_s_acc, 1'b0};

        sq_tag.status = d1_res.status;
        sq_tag.s      = d1_res.s;
        sq_tag.v0     = d1_res.v0;
        sq_tag.vt     = d1_res.vt;
        sq_tag.a      = d1_res.a;
        sq_tag.s_acc  = mid_s_acc;
        sq_tag.s_uni  = mid_s_uni;
        sq_tag.trap   = !mid_s_uni[33] && (mid_s_uni != '0);
    end

    tpp_sqrt_pipe #(
        .TAG_W ($bits(tpp_pkg::sq_side_t))
    ) u_sqrt_peak (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (d1_valid),
        .rad       (d1_res.rad),
        .tag       (sq_tag),
        .res_valid (sq_valid),
        .root      (sq_root),
        .res_tag   (sq_res)
    );

    // First preparation stage: speed change of the acceleration phase and the final
    // distances. A triangle splits the distance in half, and the odd bit lands in the cruise.
    always_comb
    begin
        if (sq_res.trap)
        begin
            p1_diff_next  = {{2{sq_res.vt[31]}}, sq_res.vt} - {{2{sq_res.v0[31]}}, sq_res.v0};
            p1_s_acc_next = sq_res.s_acc;
            p1_s_uni_next = tpp_pkg::sat_wide(sq_res.s_uni);
        end
        else
        begin
            p1_diff_next  = {2'b00, sq_root} - {{2{sq_res.v0[31]}}, sq_res.v0};
            p1_s_acc_next = {1'b0, sq_res.s[31:1]};
            p1_s_uni_next = {31'd0, sq_res.s[0]};
        end
    end

    // Second preparation stage: sign and magnitude of the time numerators.
    always_comb
    begin
        p2_dmag_next        = p1_diff_reg[33] ? 33'(-p1_diff_reg) : p1_diff_reg[32:0];
        p2_side_next.status = p1_status_reg;
        p2_side_next.s_acc  = p1_s_acc_reg;
        p2_side_next.s_uni  = p1_s_uni_reg;
        p2_side_next.dneg   = p1_diff_reg[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= sq_valid;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_status_reg <= sq_res.status;
            p1_diff_reg   <= p1_diff_next;
            p1_s_acc_reg  <= p1_s_acc_next;
            p1_s_uni_reg  <= p1_s_uni_next;
            p1_trap_reg   <= sq_res.trap;
            p1_a_reg      <= sq_res.a;
            p1_vt_reg     <= sq_res.vt;

            p2_num2_reg   <= {p2_dmag_next, {FRAC_BITS{1'b0}}};
            p2_num3_reg   <= {1'b0, p1_s_uni_reg, {FRAC_BITS{1'b0}}};
            p2_a_reg      <= p1_a_reg;
            p2_vt_reg     <= p1_vt_reg;
            p2_side_reg   <= p2_side_next;
            p2_trap_reg   <= p1_trap_reg;
        end
    end

    // Acceleration time: speed change scaled by one, divided by the acceleration.
    tpp_div_pipe #(
        .NUM_W (NUM2_W),
        .DEN_W (32),
        .TAG_W ($bits(tpp_pkg::d2_side_t))
    ) u_div_tacc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (p2_vld_reg),
        .num       (p2_num2_reg),
        .den       (p2_a_reg),
        .tag       (p2_side_reg),
        .res_valid (d2_valid),
        .quot      (d2_quot),
        .quot_ovf  (d2_ovf),
        .res_tag   (d2_res)
    );

    // Cruise time: cruise distance scaled by one, divided by the cruise speed. It runs in
    // lockstep with the acceleration time divider.
    tpp_div_pipe #(
        .NUM_W (NUM2_W),
        .DEN_W (32),
        .TAG_W (1)
    ) u_div_tuni (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (p2_vld_reg),
        .num       (p2_num3_reg),
        .den       (p2_vt_reg),
        .tag       (p2_trap_reg),
        .res_valid (d3_valid),
        .quot      (d3_quot),
        .quot_ovf  (d3_ovf),
        .res_tag   (d3_trap)
    );

    // Final stage: total time, and a result that is zero in every field but the status when the request was rejected.
    always_comb
    begin
        q2_item_next        = '0;
        q2_item_next.status = q1_status_reg;
        if (q1_status_reg == tpp_pkg::ST_OK)
        begin
            q2_item_next.time_total  = tpp_pkg::sat_wide({q1_t_acc_reg[31], q1_t_acc_reg, 1'b0} +
                                           {{2{q1_t_uni_reg[31]}}, q1_t_uni_reg});
            q2_item_next.time_accel  = q1_t_acc_reg;
            q2_item_next.time_cruise = q1_t_uni_reg;
            q2_item_next.time_decel  = q1_t_acc_reg;
            q2_item_next.dist_accel  = q1_s_acc_reg;
            q2_item_next.dist_cruise = q1_s_uni_reg;
            q2_item_next.dist_decel  = q1_s_acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q1_vld_reg <= d2_valid;
            q2_vld_reg <= q1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_status_reg <= d2_res.status;
            q1_t_acc_reg  <= tpp_pkg::sat_quot(d2_res.dneg, d2_quot, d2_ovf);
            q1_t_uni_reg  <= d3_trap ? tpp_pkg::sat_quot(1'b0, d3_quot, d3_ovf) : '0;
            q1_s_acc_reg  <= d2_res.s_acc;
            q1_s_uni_reg  <= d2_res.s_uni;
            q2_item_reg   <= q2_item_next;
        end
    end

    // Output queue: entry 0 is the head and drives the result port.
    assign push       = adv && q2_vld_reg;
    assign plan_valid = (cnt_reg != 2'd0);
    assign pop        = plan_valid && plan_ready;
    assign plan       = ent_reg[0];

    always_comb
    begin
        ent0_next = ent_reg[0];
        ent1_next = ent_reg[1];
        if (pop)
            ent0_next = ent_reg[1];
        if (push)
        begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
                ent0_next = q2_item_reg;
            else
                ent1_next = q2_item_reg;
        end
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent0_next;
        ent_reg[1] <= ent1_next;
    end

    // The two time dividers must stay in lockstep, or the cruise time pairs with another item.
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid == d3_valid)
        else $error("time dividers out of step");

    a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (plan_valid && plan.status != tpp_pkg::ST_OK) |->
        (plan.time_total == '0 && plan.time_accel == '0 && plan.dist_accel == '0 &&
         plan.dist_cruise == '0))
        else $error("rejected request carries nonzero fields");

    a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid |->
        (plan.time_decel == plan.time_accel && plan.dist_decel == plan.dist_accel))
        else $error("profile not symmetric");

endmodule
